// ===== rtl/core/umhb_pkg.sv =====
package umhb_pkg;

	localparam int unsigned HDR_LEN = 42;
	localparam logic [5:0] LAST_IDX = 6'(HDR_LEN - 1);
	localparam logic [15:0] MAX_PAYLOAD = 16'd65507;
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [15:0] IP_FLAGS_DF = 16'h4000;
	localparam logic [7:0] IP_PROTO_UDP = 8'd17;
	localparam logic [15:0] IP_HDR_LEN = 16'd28;
	localparam logic [15:0] UDP_HDR_LEN = 16'd8;
	localparam logic [23:0] MCAST_OUI = 24'h01005E;
	localparam logic [47:0] RST_SOURCE_MAC = 48'h0;
	localparam logic [31:0] RST_IP = 32'h0;
	localparam logic [7:0] RST_TTL = 8'd64;
	localparam logic [15:0] RST_PORT = 16'h0;

	typedef enum logic [2:0] {
		REG_SOURCE_MAC = 3'd0,
		REG_SOURCE_IP = 3'd1,
		REG_DEST_IP = 3'd2,
		REG_TTL = 3'd3,
		REG_DEST_PORT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [7:0] time_to_live;
		logic [15:0] dest_port;
	} cfg_regs_t;

	// per-packet fields held for the duration of one header
	typedef struct packed {
		logic [15:0] total_len;
		logic [15:0] udp_len;
		logic [15:0] checksum;
	} pkt_fields_t;

	// one's-complement sum of eight 16-bit header words (ident and checksum are zero), folded and inverted
	function automatic logic [15:0] ip_checksum(input cfg_regs_t cfg, input logic [15:0] total_len);
		logic [19:0] s;
		logic [16:0] f1;
		logic [15:0] f2;
		begin
			s = 20'({IP_VER_IHL, 8'h00}) + 20'(total_len) + 20'(IP_FLAGS_DF)
				+ 20'({cfg.time_to_live, IP_PROTO_UDP})
				+ 20'(cfg.source_ip[31:16]) + 20'(cfg.source_ip[15:0])
				+ 20'(cfg.dest_ip[31:16]) + 20'(cfg.dest_ip[15:0]);
			f1 = 17'(s[15:0]) + 17'(s[19:16]);
			f2 = f1[15:0] + 16'(f1[16]);
			return ~f2;
		end
	endfunction

endpackage

// ===== rtl/core/umhb_byte_mux.sv =====
module umhb_byte_mux (
	input  umhb_pkg::cfg_regs_t   cfg,
	input  umhb_pkg::pkt_fields_t pkt,
	input  logic [5:0]            idx,
	output logic [7:0]            byte_out
);

	always_comb begin
		unique case (idx)
			6'd0: byte_out = umhb_pkg::MCAST_OUI[23:16];
			6'd1: byte_out = umhb_pkg::MCAST_OUI[15:8];
			6'd2: byte_out = umhb_pkg::MCAST_OUI[7:0];
			6'd3: byte_out = {1'b0, cfg.dest_ip[22:16]};
			6'd4: byte_out = cfg.dest_ip[15:8];
			6'd5: byte_out = cfg.dest_ip[7:0];
			6'd6: byte_out = cfg.source_mac[47:40];
			6'd7: byte_out = cfg.source_mac[39:32];
			6'd8: byte_out = cfg.source_mac[31:24];
			6'd9: byte_out = cfg.source_mac[23:16];
			6'd10: byte_out = cfg.source_mac[15:8];
			6'd11: byte_out = cfg.source_mac[7:0];
			6'd12: byte_out = umhb_pkg::ETHERTYPE_IPV4[15:8];
			6'd13: byte_out = umhb_pkg::ETHERTYPE_IPV4[7:0];
			6'd14: byte_out = umhb_pkg::IP_VER_IHL;
			6'd16: byte_out = pkt.total_len[15:8];
			6'd17: byte_out = pkt.total_len[7:0];
			6'd20: byte_out = umhb_pkg::IP_FLAGS_DF[15:8];
			6'd21: byte_out = umhb_pkg::IP_FLAGS_DF[7:0];
			6'd22: byte_out = cfg.time_to_live;
			6'd23: byte_out = umhb_pkg::IP_PROTO_UDP;
			6'd24: byte_out = pkt.checksum[15:8];
			6'd25: byte_out = pkt.checksum[7:0];
			6'd26: byte_out = cfg.source_ip[31:24];
			6'd27: byte_out = cfg.source_ip[23:16];
			6'd28: byte_out = cfg.source_ip[15:8];
			6'd29: byte_out = cfg.source_ip[7:0];
			6'd30: byte_out = cfg.dest_ip[31:24];
			6'd31: byte_out = cfg.dest_ip[23:16];
			6'd32: byte_out = cfg.dest_ip[15:8];
			6'd33: byte_out = cfg.dest_ip[7:0];
			6'd36: byte_out = cfg.dest_port[15:8];
			6'd37: byte_out = cfg.dest_port[7:0];
			6'd38: byte_out = pkt.udp_len[15:8];
			6'd39: byte_out = pkt.udp_len[7:0];
			// DSCP, ident, source port, UDP checksum
			default: byte_out = 8'h00;
		endcase
	end

endmodule

// ===== rtl/core/udp_multicast_header_builder_top.sv =====
// A started packet moves from the holding slot into the byte counter; each byte is registered on output.
// Throughput: one byte per cycle, 42 bytes per packet; a second packet is
// taken into a one-deep holding slot while the current header streams out.
// busy is high while that slot is occupied; the receiver cannot stall.
// Reset (arst_n low, asynchronous): no transaction in flight, config registers
// return to their defaults (TTL 64, everything else zero).
module udp_multicast_header_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] payload_size,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	output logic        result_valid,
	output logic [7:0]  byte_value,
	output logic [5:0]  byte_index,
	output logic        last_byte,
	output logic        size_error
);

	umhb_pkg::cfg_regs_t   cfg_q;
	umhb_pkg::pkt_fields_t pkt_q;
	umhb_pkg::pkt_fields_t pkt_next;
	logic        pend_q;
	logic [15:0] pend_size_q;
	logic        act_q;
	logic [5:0]  cnt_q;
	logic        err_q;
	logic        load;
	logic        at_last;
	logic [7:0]  mux_byte;

	assign cfg_ready = 1'b1;
	assign busy = pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_mac <= umhb_pkg::RST_SOURCE_MAC;
			cfg_q.source_ip <= umhb_pkg::RST_IP;
			cfg_q.dest_ip <= umhb_pkg::RST_IP;
			cfg_q.time_to_live <= umhb_pkg::RST_TTL;
			cfg_q.dest_port <= umhb_pkg::RST_PORT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (umhb_pkg::cfg_reg_t'(cfg_index))
				umhb_pkg::REG_SOURCE_MAC: cfg_q.source_mac <= cfg_data;
				umhb_pkg::REG_SOURCE_IP: cfg_q.source_ip <= cfg_data[31:0];
				umhb_pkg::REG_DEST_IP: cfg_q.dest_ip <= cfg_data[31:0];
				umhb_pkg::REG_TTL: cfg_q.time_to_live <= cfg_data[7:0];
				umhb_pkg::REG_DEST_PORT: cfg_q.dest_port <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign at_last = (cnt_q == umhb_pkg::LAST_IDX);
	// hand the held packet to the byte counter when it is free or wrapping
	assign load = pend_q && (!act_q || at_last);

	always_comb begin
		pkt_next.total_len = pend_size_q + umhb_pkg::IP_HDR_LEN;
		pkt_next.udp_len = pend_size_q + umhb_pkg::UDP_HDR_LEN;
		pkt_next.checksum = umhb_pkg::ip_checksum(cfg_q, pkt_next.total_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (start && !busy) begin
			pend_q <= 1'b1;
		end else if (load) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pend_size_q <= payload_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			act_q <= 1'b1;
			cnt_q <= '0;
		end else if (act_q) begin
			if (at_last) begin
				act_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pkt_q <= pkt_next;
			err_q <= (pend_size_q > umhb_pkg::MAX_PAYLOAD);
		end
	end

	umhb_byte_mux u_mux (
		.cfg      (cfg_q),
		.pkt      (pkt_q),
		.idx      (cnt_q),
		.byte_out (mux_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= act_q;
		end
	end

	always_ff @(posedge clk) begin
		byte_value <= mux_byte;
		byte_index <= cnt_q;
		last_byte <= act_q && at_last;
		size_error <= err_q;
	end

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_byte |-> byte_index == umhb_pkg::LAST_IDX)
		else $error("last byte flagged at wrong index");

	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_byte |=> result_valid && byte_index == $past(byte_index) + 6'd1)
		else $error("header bytes not contiguous");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted packet not held");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		act_q && !at_last |=> act_q && cnt_q == $past(cnt_q) + 6'd1)
		else $error("byte counter skipped");

endmodule

// ===== sim/udp_multicast_header_builder_top_tb.sv =====
module udp_multicast_header_builder_top_tb;

	localparam int HDR_BYTES = 42;
	localparam logic [15:0] MAX_UDP_PAYLOAD = 16'd65507;
	localparam int DRAIN_CYCLES = 6;
	localparam int TIMEOUT = 3_000_000;
	localparam int PKTS_PER_PHASE = 160;
	localparam int MAX_PRINTED = 50;
	// indexes with no register behind them
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_PKT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [47:0] data;
		logic [15:0] size;
		logic        typed;
		logic        err;
		logic [15:0] ip_len;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] value;
		logic [5:0] index;
		logic       last;
		logic       err;
	} hdr_byte_t;

	localparam int N_DIR = 28;
	// typed rows carry size_error and the IPv4 total length by hand
	localparam stim_row_t DIR_ROWS [N_DIR] = '{
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd0, 1'b1, 1'b0, 16'h001C},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65507, 1'b1, 1'b0, 16'hFFFF},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65508, 1'b1, 1'b1, 16'h0000},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65535, 1'b1, 1'b1, 16'h001B},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'h5555, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'hAAAA, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_SOURCE_IP, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_DEST_IP, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_TTL, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_DEST_PORT, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, REG_SPARE_LO, 48'h1234_5678_9ABC, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, REG_SPARE_HI, 48'hFFFF_FFFF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd0, 1'b1, 1'b0, 16'h001C},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65535, 1'b1, 1'b1, 16'h001B},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65507, 1'b1, 1'b0, 16'hFFFF},
		'{ROW_CFG, umhb_pkg::REG_SOURCE_MAC, 48'h0123_4567_89AB, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_SOURCE_IP, 48'hABCD_C0A8_0001, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_DEST_IP, 48'h0000_EF01_0203, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_TTL, 48'h0000_0000_0001, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_DEST_PORT, 48'h0000_0000_138C, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd1200, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd65479, 1'b1, 1'b0, 16'hFFE3},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'hFFFE, 1'b1, 1'b1, 16'h001A},
		'{ROW_CFG, umhb_pkg::REG_TTL, 48'h0, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_CFG, umhb_pkg::REG_DEST_IP, 48'h0000_E0FF_FFFF, 16'd0, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd100, 1'b0, 1'b0, 16'h0},
		'{ROW_PKT, umhb_pkg::REG_SOURCE_MAC, 48'h0, 16'd8, 1'b0, 1'b0, 16'h0}
	};

	localparam int N_PHASES = 3;
	localparam int IDLE_PCT [N_PHASES] = '{0, 78, 10};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [15:0] payload_size = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;
	logic        result_valid;
	logic [7:0]  byte_value;
	logic [5:0]  byte_index;
	logic        last_byte;
	logic        size_error;

	// register copies as the block should hold them
	logic [47:0] src_mac_q = '0;
	logic [31:0] src_ip_q = '0;
	logic [31:0] dst_ip_q = '0;
	logic [7:0]  ttl_q = 8'd64;
	logic [15:0] dst_port_q = '0;

	hdr_byte_t header_bytes_q [$];
	int n_errs = 0;
	int n_pkts = 0;
	int n_oversize = 0;
	int n_bytes = 0;
	int n_cfg = 0;

	udp_multicast_header_builder_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.payload_size(payload_size),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.byte_value(byte_value),
		.byte_index(byte_index),
		.last_byte(last_byte),
		.size_error(size_error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#TIMEOUT;
		$display("udp_multicast_header_builder_top_tb failed");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		begin
			if (n_errs < MAX_PRINTED)
				$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
			n_errs++;
		end
	endtask

	// works out the 42 header bytes for one packet from the register copies
	task automatic build_header(input logic [15:0] size, input logic typed, input logic err_t,
			input logic [15:0] len_t);
		logic [7:0] h [HDR_BYTES];
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [31:0] acc;
		logic [15:0] csum;
		logic err;
		hdr_byte_t b;
		begin
			ip_len = size + 16'd28;
			udp_len = size + 16'd8;
			err = size > MAX_UDP_PAYLOAD;
			h[0] = 8'h01;
			h[1] = 8'h00;
			h[2] = 8'h5E;
			h[3] = {1'b0, dst_ip_q[22:16]};
			h[4] = dst_ip_q[15:8];
			h[5] = dst_ip_q[7:0];
			for (int i = 0; i < 6; i++)
				h[6 + i] = src_mac_q[47 - 8 * i -: 8];
			h[12] = 8'h08;
			h[13] = 8'h00;
			h[14] = 8'h45;
			h[15] = 8'h00;
			h[16] = ip_len[15:8];
			h[17] = ip_len[7:0];
			h[18] = 8'h00;
			h[19] = 8'h00;
			h[20] = 8'h40;
			h[21] = 8'h00;
			h[22] = ttl_q;
			h[23] = 8'd17;
			h[24] = 8'h00;
			h[25] = 8'h00;
			for (int i = 0; i < 4; i++) begin
				h[26 + i] = src_ip_q[31 - 8 * i -: 8];
				h[30 + i] = dst_ip_q[31 - 8 * i -: 8];
			end
			acc = '0;
			for (int i = 14; i < 34; i += 2)
				acc += {16'h0, h[i], h[i + 1]};
			acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
			acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
			csum = ~acc[15:0];
			h[24] = csum[15:8];
			h[25] = csum[7:0];
			h[34] = 8'h00;
			h[35] = 8'h00;
			h[36] = dst_port_q[15:8];
			h[37] = dst_port_q[7:0];
			h[38] = udp_len[15:8];
			h[39] = udp_len[7:0];
			h[40] = 8'h00;
			h[41] = 8'h00;
			if (typed) begin
				err = err_t;
				h[16] = len_t[15:8];
				h[17] = len_t[7:0];
			end
			if (err)
				n_oversize++;
			for (int i = 0; i < HDR_BYTES; i++) begin
				b.value = h[i];
				b.index = 6'(i);
				b.last = (i == HDR_BYTES - 1);
				b.err = err;
				header_bytes_q.push_back(b);
			end
		end
	endtask

	// drop start and let everything in flight drain out
	task automatic quiesce();
		begin
			start <= 1'b0;
			while (header_bytes_q.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
		begin
			quiesce();
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;
			case (idx)
				umhb_pkg::REG_SOURCE_MAC: src_mac_q = data;
				umhb_pkg::REG_SOURCE_IP: src_ip_q = data[31:0];
				umhb_pkg::REG_DEST_IP: dst_ip_q = data[31:0];
				umhb_pkg::REG_TTL: ttl_q = data[7:0];
				umhb_pkg::REG_DEST_PORT: dst_port_q = data[15:0];
				default: ;
			endcase
			n_cfg++;
		end
	endtask

	task automatic send_packet(input logic [15:0] size, input int idle_pct, input logic typed,
			input logic err_t, input logic [15:0] len_t);
		begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				do @(posedge clk); while ($urandom_range(99) < idle_pct);
			end
			start <= 1'b1;
			payload_size <= size;
			do @(posedge clk); while (busy);
			build_header(size, typed, err_t, len_t);
			n_pkts++;
		end
	endtask

	function automatic logic [47:0] pick_reg_value();
		case ($urandom_range(3))
			0: return 48'h0;
			1: return 48'hFFFF_FFFF_FFFF;
			default: return {16'($urandom_range(16'hFFFF)), $urandom};
		endcase
	endfunction

	function automatic logic [15:0] pick_size();
		int r;
		begin
			r = $urandom_range(99);
			if (r < 60)
				return 16'($urandom_range(65535));
			else if (r < 82)
				return 16'($urandom_range(65535, 65490));
			else
				return 16'($urandom_range(1500));
		end
	endfunction

	always @(posedge clk) begin : result_check
		hdr_byte_t want;
		if (arst_n && result_valid) begin
			if (header_bytes_q.size() == 0) begin
				report_mismatch("unexpected byte, index", byte_index, 0);
			end else begin
				want = header_bytes_q.pop_front();
				n_bytes++;
				if (byte_value !== want.value)
					report_mismatch($sformatf("byte_value at %0d", want.index), byte_value,
						want.value);
				if (byte_index !== want.index)
					report_mismatch("byte_index", byte_index, want.index);
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte at %0d", want.index), last_byte,
						want.last);
				if (size_error !== want.err)
					report_mismatch($sformatf("size_error at %0d", want.index), size_error,
						want.err);
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			if (DIR_ROWS[r].kind == ROW_CFG)
				write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
			else
				send_packet(DIR_ROWS[r].size, 0, DIR_ROWS[r].typed, DIR_ROWS[r].err,
					DIR_ROWS[r].ip_len);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			for (int k = umhb_pkg::REG_SOURCE_MAC; k <= umhb_pkg::REG_DEST_PORT; k++)
				write_reg(umhb_pkg::cfg_reg_t'(k), pick_reg_value());
			write_reg(REG_SPARE_HI, pick_reg_value());
			for (int n = 0; n < PKTS_PER_PHASE; n++)
				send_packet(pick_size(), IDLE_PCT[p], 1'b0, 1'b0, 16'h0);
		end

		quiesce();
		$display("sent %0d packets (%0d oversize), checked %0d header bytes", n_pkts,
			n_oversize, n_bytes);
		$display("%0d register writes over %0d traffic phases, %0d mismatches", n_cfg,
			N_PHASES + 1, n_errs);
		if (n_errs == 0 && header_bytes_q.size() == 0) begin
			$display("udp_multicast_header_builder_top_tb passed");
		end else begin
			$display("udp_multicast_header_builder_top_tb failed");
		end
		$finish;
	end

endmodule
